>>> rtl/core/assert_macros.svh
// shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IRTL_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define IRTL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/irtl_pkg.sv
package irtl_pkg;

   // default table size
   localparam int TABLE_DEPTH_DEF = 65536;

   // field widths
   localparam int INDEX_W = 16;
   localparam int IP_W    = 32;
   localparam int COUNT_W = 17;

   // stream payload widths
   localparam int REQ_TDATA_W = INDEX_W + 3 * IP_W;
   localparam int RSP_TDATA_W = INDEX_W;

   // action codes
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

endpackage

>>> rtl/core/irtl_ram.sv
module irtl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ip_range_table_lookup.sv
// IPv4 range table with binary-search lookup. Software writes sorted
// (start, end) ranges into the table through write transfers on the request
// stream and sets entry_count through the register port while the block is
// idle. A write transfer gives no response. A lookup transfer carries an
// address; the block searches for the first entry whose start is not below
// it, picks that entry on an exact start match and the entry before it
// otherwise, and answers with hit and the entry index when start <= address
// <= end. The time a lookup takes is set by the single read port of the
// table RAM: one registered read per halving step over the N live entries,
// N being entry_count capped at the table depth, plus reads of the chosen
// entry. One lookup is in flight at a time; a finished response waits in
// its output register while the next transfer is accepted, and a lookup
// that finishes while that register is still full holds the request side
// until the response leaves. Table contents are undefined until written
// and there is no clearing pass after reset.

`include "assert_macros.svh"

module ip_range_table_lookup #(
   parameter int TABLE_DEPTH = irtl_pkg::TABLE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata, lowest bit up: entry_index[15:0], range_start[31:0],
   // range_end[31:0], address[31:0]
   input  logic [irtl_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: action
   input  logic [0:0]                         req_tuser,

   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: hit_index[15:0]
   output logic [irtl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // tuser: hit
   output logic [0:0]                         rsp_tuser,

   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   import irtl_pkg::*;

   // table address bits and a count wide enough to hold the depth itself
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_LOW,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type           state_ff;

   logic [COUNT_W-1:0]  entry_count_ff;

   // search registers
   logic [IP_W-1:0]     addr_ff;
   logic [CW-1:0]       total_ff;
   logic [CW-1:0]       lo_ff;
   logic [CW-1:0]       n_ff;
   logic [CW-1:0]       mid_ff;
   logic [CW-1:0]       sel_ff;

   // finished result, then the output register
   logic                res_hit_ff;
   logic [INDEX_W-1:0]  res_idx_ff;
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [INDEX_W-1:0]  rsp_idx_ff;
   logic                rsp_load;

   // request fields
   logic                req_action;
   logic [INDEX_W-1:0]  req_index;
   logic [IP_W-1:0]     req_start;
   logic [IP_W-1:0]     req_end;
   logic [IP_W-1:0]     req_addr;
   logic                req_xfer;

   // table ram, end in the upper half
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [2*IP_W-1:0]   ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [2*IP_W-1:0]   ram_rdata;
   logic [IP_W-1:0]     rd_start;
   logic [IP_W-1:0]     rd_end;

   // entry count capped at the depth
   logic [31:0]         count_wide;
   logic [CW-1:0]       total_c;

   // both successor candidates of one halving step
   logic                below;
   logic [CW-1:0]       half;
   logic [CW-1:0]       lo_lt;
   logic [CW-1:0]       n_lt;
   logic [CW-1:0]       mid_lt;
   logic [CW-1:0]       mid_ge;
   logic [CW-1:0]       lo_nx;
   logic [CW-1:0]       n_nx;
   logic [CW-1:0]       mid_nx;
   logic [CW-1:0]       rd_ptr;

   assign req_action = req_tuser[0];
   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_start  = req_tdata[INDEX_W +: IP_W];
   assign req_end    = req_tdata[INDEX_W+IP_W +: IP_W];
   assign req_addr   = req_tdata[INDEX_W+2*IP_W +: IP_W];

   // one item at a time; a waiting response does not block acceptance
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign count_wide = {{(32-COUNT_W){1'b0}}, entry_count_ff};
   assign total_c    = (count_wide > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_wide);

   // writes beyond the depth are dropped
   assign ram_we    = req_xfer && (req_action == ACT_WRITE) &&
                      ({16'b0, req_index} < 32'(TABLE_DEPTH));
   assign ram_waddr = AW'(req_index);
   assign ram_wdata = {req_end, req_start};

   assign rd_start = ram_rdata[IP_W-1:0];
   assign rd_end   = ram_rdata[2*IP_W-1:IP_W];

   always_comb begin
      below  = rd_start < addr_ff;
      half   = n_ff >> 1;
      lo_lt  = mid_ff + CW'(1);
      n_lt   = n_ff - half - CW'(1);
      mid_lt = lo_lt + (n_lt >> 1);
      mid_ge = lo_ff + (half >> 1);
      lo_nx  = below ? lo_lt : lo_ff;
      n_nx   = below ? n_lt : half;
      mid_nx = below ? mid_lt : mid_ge;
   end

   // read address: the probe of the next step, or the entry to be checked
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            rd_ptr = total_c >> 1;
         end
         ST_SEARCH: begin
            if (n_nx != '0) begin
               rd_ptr = mid_nx;
            end else if (lo_nx != total_ff) begin
               rd_ptr = lo_nx;
            end else begin
               rd_ptr = total_ff - CW'(1);
            end
         end
         ST_LOW: begin
            rd_ptr = lo_ff - CW'(1);
         end
         default: begin
            rd_ptr = lo_ff;
         end
      endcase
   end

   assign ram_raddr = AW'(rd_ptr);

   irtl_ram #(
      .WIDTH (2 * IP_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // finished result moves on once the output register is free
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // search sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer && (req_action == ACT_LOOKUP)) begin
                  addr_ff  <= req_addr;
                  total_ff <= total_c;
                  lo_ff    <= '0;
                  n_ff     <= total_c;
                  mid_ff   <= total_c >> 1;
                  if (total_c == '0) begin
                     // empty table always misses
                     res_hit_ff <= 1'b0;
                     res_idx_ff <= '0;
                     state_ff   <= ST_DONE;
                  end else begin
                     state_ff <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               lo_ff  <= lo_nx;
               n_ff   <= n_nx;
               mid_ff <= mid_nx;
               if (n_nx == '0) begin
                  if (lo_nx != total_ff) begin
                     state_ff <= ST_LOW;
                  end else begin
                     // every start below the address: last entry
                     sel_ff   <= total_ff - CW'(1);
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_LOW: begin
               if (rd_start == addr_ff) begin
                  res_hit_ff <= (addr_ff <= rd_end);
                  res_idx_ff <= (addr_ff <= rd_end) ? INDEX_W'(lo_ff) : '0;
                  state_ff   <= ST_DONE;
               end else if (lo_ff != '0) begin
                  sel_ff   <= lo_ff - CW'(1);
                  state_ff <= ST_CHECK;
               end else begin
                  // address below every start
                  res_hit_ff <= 1'b0;
                  res_idx_ff <= '0;
                  state_ff   <= ST_DONE;
               end
            end
            ST_CHECK: begin
               res_hit_ff <= (rd_start <= addr_ff) && (addr_ff <= rd_end);
               res_idx_ff <= ((rd_start <= addr_ff) && (addr_ff <= rd_end)) ?
                             INDEX_W'(sel_ff) : '0;
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               // hand over once the output register is free
               if (rsp_load) begin
                  rsp_hit_ff <= res_hit_ff;
                  rsp_idx_ff <= res_idx_ff;
                  state_ff   <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_idx_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

   // register port, entry_count at byte address 0
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         entry_count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'b0 : {{(32-COUNT_W){1'b0}}, entry_count_ff};

   // probes stay inside the live part of the table
   `IRTL_ASSERT_IMPLY(a_probe_in_range, clock, reset,
      state_ff == ST_SEARCH, (n_ff != '0) && (mid_ff < total_ff))
   `IRTL_ASSERT_IMPLY(a_window_in_range, clock, reset,
      state_ff == ST_SEARCH, ({1'b0, lo_ff} + {1'b0, n_ff}) <= {1'b0, total_ff})
   // a miss carries index zero
   `IRTL_ASSERT_IMPLY(a_miss_index_zero, clock, reset,
      rsp_valid_ff && !rsp_hit_ff, rsp_idx_ff == '0)
   // an accepted lookup leaves idle
   `IRTL_ASSERT_NEXT(a_lookup_starts, clock, reset,
      req_xfer && (req_action == ACT_LOOKUP), state_ff != ST_IDLE)

endmodule

>>> dv/ip_range_table_lookup_checker.sv
`timescale 1ns / 100ps

module ip_range_table_lookup_checker #(
   parameter int         TABLE_DEPTH    = irtl_pkg::TABLE_DEPTH_DEF,
   parameter logic [2:0] COUNT_REG_ADDR = 3'd0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [irtl_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]                       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [irtl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [0:0]                       rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [2:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   input  logic [31:0]                      csr_prdata,
   input  logic                             csr_pready,
   output int                               fail_count,
   output int                               outstanding,
   output int                               lookups_seen,
   output int                               hits_seen,
   output int                               writes_seen
);
   import irtl_pkg::*;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] index;
   } match_type;

   bit   [IP_W-1:0]    start_mem [TABLE_DEPTH];
   bit   [IP_W-1:0]    end_mem   [TABLE_DEPTH];
   logic [COUNT_W-1:0] entry_count = '0;
   match_type          awaited[$];
   int                 fails   = 0;
   int                 lookups = 0;
   int                 hits    = 0;
   int                 writes  = 0;

   // first start not below the address, then exact match or the entry before it
   function automatic match_type search_ranges(input logic [IP_W-1:0] addr);
      int unsigned total, lo, span, half, mid, sel;
      bit          found;
      match_type   m;
      total = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
      lo    = 0;
      span  = total;
      sel   = 0;
      found = 1'b0;
      while (span > 0) begin
         half = span >> 1;
         mid  = lo + half;
         if (start_mem[mid] < addr) begin
            lo   = mid + 1;
            span = span - (half + 1);
         end else begin
            span = half;
         end
      end
      if (lo != total) begin
         if (start_mem[lo] == addr) begin
            sel   = lo;
            found = 1'b1;
         end else if (lo > 0) begin
            sel   = lo - 1;
            found = 1'b1;
         end
      end else if (total > 0) begin
         sel   = total - 1;
         found = 1'b1;
      end
      m.hit   = found && start_mem[sel] <= addr && addr <= end_mem[sel];
      m.index = m.hit ? sel[INDEX_W-1:0] : '0;
      return m;
   endfunction

   always @(posedge clock) begin
      match_type          got, want;
      logic [INDEX_W-1:0] idx;
      if (reset) begin
         awaited.delete();
         entry_count = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == COUNT_REG_ADDR) begin
            if (csr_pwrite) begin
               entry_count = csr_pwdata[COUNT_W-1:0];
            end else if (csr_prdata !== {{(32-COUNT_W){1'b0}}, entry_count}) begin
               $error("entry_count: expected %0d, got %0d", entry_count, csr_prdata);
               fails++;
            end
         end

         // responses before requests: a lookup never answers in its own cycle
         if (rsp_tvalid && rsp_tready) begin
            got.hit   = rsp_tuser[0];
            got.index = rsp_tdata;
            if (awaited.size() == 0) begin
               $error("response with no lookup waiting: hit %0d, hit_index %0d",
                      got.hit, got.index);
               fails++;
            end else begin
               want = awaited.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, got.hit);
                  fails++;
               end
               if (got.index !== want.index) begin
                  $error("hit_index: expected %0d, got %0d", want.index, got.index);
                  fails++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == ACT_WRITE) begin
               idx = req_tdata[INDEX_W-1:0];
               if (idx < TABLE_DEPTH) begin
                  start_mem[idx] = req_tdata[INDEX_W +: IP_W];
                  end_mem[idx]   = req_tdata[INDEX_W+IP_W +: IP_W];
               end
               writes++;
            end else begin
               want = search_ranges(req_tdata[INDEX_W+2*IP_W +: IP_W]);
               awaited.push_back(want);
               lookups++;
               if (want.hit) hits++;
            end
         end
      end
      fail_count   <= fails;
      outstanding  <= awaited.size();
      lookups_seen <= lookups;
      hits_seen    <= hits;
      writes_seen  <= writes;
   end

endmodule

>>> dv/ip_range_table_lookup_tb.sv
`timescale 1ns / 100ps

module ip_range_table_lookup_tb;
   import irtl_pkg::*;

   localparam int         TABLE_DEPTH       = TABLE_DEPTH_DEF;
   localparam logic [2:0] ENTRY_COUNT_ADDR  = 3'd0;
   localparam int         CLK_PERIOD        = 20;
   localparam int         RANDOM_ITEMS      = 1000;
   localparam int         DRAIN_CYCLES      = 30;
   localparam int         HOLDOFF_CYCLES    = 300;
   localparam longint     TIMEOUT_CYCLES    = 1_000_000;

   // shapes of the range sets loaded before a phase
   typedef enum {LAYOUT_DISJOINT, LAYOUT_OVERLAP, LAYOUT_SHUFFLED} layout_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   // tdata, lowest bit up: entry_index, range_start, range_end, address
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   // tuser: action
   logic [0:0]             req_tuser   = ACT_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   // tdata: hit_index
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // tuser: hit
   logic [0:0]             rsp_tuser;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [2:0]             csr_paddr   = ENTRY_COUNT_ADDR;
   logic [31:0]            csr_pwdata  = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int fail_count, outstanding, lookups_seen, hits_seen, writes_seen;

   // what the stimulus believes the table holds, used only to aim addresses
   logic [IP_W-1:0] range_first [TABLE_DEPTH];
   logic [IP_W-1:0] range_last  [TABLE_DEPTH];
   bit              written     [TABLE_DEPTH];

   bit gaps_on         = 1'b0;
   int gap_odds        = 3;
   bit stalls_on       = 1'b0;
   bit holdoff_pending = 1'b0;
   int items_sent      = 0;
   int settings_used   = 0;
   int live_count      = 0;

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   ip_range_table_lookup #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ip_range_table_lookup_checker #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .COUNT_REG_ADDR (ENTRY_COUNT_ADDR)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .lookups_seen (lookups_seen),
      .hits_seen    (hits_seen),
      .writes_seen  (writes_seen)
   );

   // offer one request and hold it until the transfer happens
   task automatic send_req(input logic act, input logic [INDEX_W-1:0] idx,
                           input logic [IP_W-1:0] first, input logic [IP_W-1:0] last,
                           input logic [IP_W-1:0] addr);
      if (gaps_on && $urandom_range(0, gap_odds) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {addr, last, first, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == ACT_WRITE && idx < TABLE_DEPTH) begin
         range_first[idx] = first;
         range_last[idx]  = last;
         written[idx]     = 1'b1;
      end
      items_sent++;
   endtask

   // unused fields carry random noise
   task automatic store_range(input logic [INDEX_W-1:0] idx, input logic [IP_W-1:0] first,
                              input logic [IP_W-1:0] last);
      send_req(ACT_WRITE, idx, first, last, $urandom);
   endtask

   // write an entry once if still empty, sorted by start;
   // entry 0 starts above zero and the last entry runs to the top address
   task automatic fill_entry(input int unsigned p);
      logic [IP_W-1:0] first, last;
      if (!written[p]) begin
         first = {16'(p), 1'b0, 15'($urandom)};
         if (p == 0) first = 32'd5;
         last = (p == TABLE_DEPTH - 1) ? 32'hFFFF_FFFF : first + $urandom_range(0, 32'h7FFF);
         store_range(16'(p), first, last);
      end
   endtask

   // write every still empty entry that a lookup of addr over n entries reads
   task automatic cover_path(input logic [IP_W-1:0] addr, input int n);
      int unsigned lo, span, half, mid;
      lo   = 0;
      span = n;
      while (span > 0) begin
         half = span >> 1;
         mid  = lo + half;
         fill_entry(mid);
         if (range_first[mid] < addr) begin
            lo   = mid + 1;
            span = span - (half + 1);
         end else begin
            span = half;
         end
      end
      if (lo < n) fill_entry(lo);
      if (lo > 0) fill_entry(lo - 1);
   endtask

   task automatic look_up(input logic [IP_W-1:0] addr);
      cover_path(addr, live_count);
      send_req(ACT_LOOKUP, 16'($urandom), $urandom, $urandom, addr);
   endtask

   // entry_count only changes once the block has gone quiet
   task automatic set_entry_count(input logic [COUNT_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ENTRY_COUNT_ADDR;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      // read back straight away, the checker compares the value
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      live_count = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
      settings_used++;
   endtask

   // rewrite the first n entries with a fresh range set
   task automatic load_ranges(input int n, input layout_type layout);
      longint unsigned stride, first, last;
      stride = 64'd4294967296 / n;
      for (int i = 0; i < n; i++) begin
         case (layout)
            LAYOUT_DISJOINT: begin
               first = i * stride + $urandom_range(0, stride / 4);
               last  = first + $urandom_range(0, stride / 2);
            end
            LAYOUT_OVERLAP: begin
               // reaches into the following ranges
               first = i * stride + $urandom_range(0, stride / 4);
               last  = first + 2 * longint'($urandom_range(0, stride / 2));
               if (last > 64'hFFFF_FFFF) last = 64'hFFFF_FFFF;
            end
            default: begin
               // unsorted, and now and then an inverted range
               first = $urandom;
               last  = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : first + $urandom_range(0, 32'h00FF_FFFF);
            end
         endcase
         store_range(16'(i), first[IP_W-1:0], last[IP_W-1:0]);
      end
   endtask

   // aim at or just past the edges of a range half of the time
   function automatic logic [IP_W-1:0] pick_address(input int n);
      int unsigned     k;
      logic [IP_W-1:0] lo_a, hi_a;
      if (n <= 0) return $urandom;
      k    = $urandom_range(0, n - 1);
      if (!written[k]) return $urandom;
      lo_a = range_first[k];
      hi_a = range_last[k];
      case ($urandom_range(0, 7)) inside
         0:       return lo_a;
         1:       return hi_a;
         2:       return lo_a - 1;
         3:       return hi_a + 1;
         4, 5:    return (hi_a >= lo_a) ? lo_a + $urandom_range(0, hi_a - lo_a) : lo_a;
         6:       return $urandom;
         default: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      endcase
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         if (holdoff_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_pending = 1'b0;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int               mark, phase, r, n, rounds, k;
      logic [COUNT_W-1:0] count_val;
      layout_type       layout;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table straight after reset: every lookup misses
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      look_up(32'h0);
      look_up(32'hFFFF_FFFF);

      // full table: below all starts, exact starts, top entry, range end and gap;
      // only the entries that a lookup reads get written
      set_entry_count(17'd65536);
      fill_entry(0);
      fill_entry(32768);
      fill_entry(40000);
      look_up(32'h0);
      look_up(range_first[0]);
      look_up(32'hFFFF_FFFF);
      look_up(range_first[32768]);
      look_up(range_last[40000]);
      look_up(range_last[40000] + 1);

      // counts past the depth saturate
      set_entry_count(17'd65537);
      fill_entry(1);
      look_up(32'hFFFF_FFFF);
      look_up(range_last[1]);
      set_entry_count(17'h1FFFF);
      fill_entry(21845);
      look_up(range_first[21845] + 1);

      // single entry
      set_entry_count(17'd1);
      look_up(range_first[0]);
      look_up(range_last[0]);
      look_up(range_last[0] + 1);
      look_up(32'd4);

      // random phases: pick a count, load a small range set for small counts, set the count, then mostly lookups
      mark  = items_sent;
      phase = 0;
      while (items_sent - mark < RANDOM_ITEMS) begin
         if (items_sent - mark >= RANDOM_ITEMS * 85 / 100) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end else begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
         end

         r = $urandom_range(0, 99);
         if (r < 5) begin
            count_val = '0;
         end else if (r < 9) begin
            count_val = 17'd65536;
         end else if (r < 12) begin
            count_val = 17'($urandom_range(65537, 131071));
         end else begin
            count_val = 17'($urandom_range(1, 40));
            r = $urandom_range(0, 9);
            layout = (r < 7) ? LAYOUT_DISJOINT : (r < 8) ? LAYOUT_OVERLAP : LAYOUT_SHUFFLED;
            load_ranges(int'(count_val), layout);
         end
         set_entry_count(count_val);
         n = (count_val > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_val);

         // first phase: hold results back long enough that the request side backs up
         if (phase == 0) holdoff_pending = 1'b1;

         rounds = (count_val > 40) ? $urandom_range(4, 8) : $urandom_range(10, 40);
         for (int j = 0; j < rounds; j++) begin
            if (n > 0 && n <= 40 && $urandom_range(0, 7) == 0) begin
               // overwrite an entry in use while lookups are running
               k = $urandom_range(0, n - 1);
               if ($urandom_range(0, 1))
                  store_range(16'(k), range_first[k], range_first[k] + $urandom_range(0, 1 << 16));
               else
                  store_range(16'(k), $urandom, $urandom);
            end else begin
               look_up(pick_address(n));
            end
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d table writes and %0d lookups (%0d hits) over %0d count settings",
               writes_seen, lookups_seen, hits_seen, settings_used);
      $display("empty, full and saturated tables, unsorted and overlapping ranges, long stall");
      if (fail_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
